### sv/tlik_pkg.sv
// Shared constants, types and functions for the two-link arm inverse kinematics block.
package tlik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int ROT_STAGES    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int DIV_STEPS     = 29;
    localparam int SQRT_STEPS    = 29;
    localparam int NORM_HALF     = 5;
    localparam int NORM_STEPS    = 2 * NORM_HALF;
    localparam int VEC_LAT       = NORM_STEPS + ROT_STAGES;
    localparam int PIPE_LAT      = DIV_STEPS + SQRT_STEPS + VEC_LAT + 10;

    localparam int MAG_W = 46;
    localparam int ROT_W = 34;
    localparam int ANG_W = 33;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [33:0]      PI_Q30      = 34'sd3373259426;
    localparam logic [14:0]             PI_CODE     = 15'd25736;

    typedef enum logic {
        REG_A1 = 1'b0,
        REG_A2 = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic               valid;
        logic               oor;
        logic               neg;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [15:0]        a1;
        logic [15:0]        a2;
        logic signed [29:0] c;
    } t_side;

    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] to_code(input logic signed [33:0] z);
        logic [33:0] t;
        logic [16:0] c;
        logic [14:0] r;
        t = unsigned'(z) + 34'd65536;
        c = t[33:17];
        if (z < 0) begin
            r = '0;
        end else if (c > 17'(PI_CODE)) begin
            r = PI_CODE;
        end else begin
            r = c[14:0];
        end
        return r;
    endfunction

endpackage

### sv/two_link_arm_inverse_kinematics.sv
// Top level: register port, law-of-cosines front end, divider, root and angle chains.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-----------------------------------------------
//   request   | start / busy        | i_x_pos, i_y_pos
//   result    | o_done strobe       | o_shoulder_angle, o_elbow_angle, o_out_of_reach
//   registers | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// One request is taken every cycle; busy stays low.
// Each result passes the 29-cell divider, the 29-cell square root and the vector angle chain.
// Synchronous active-low reset clears the link registers to their defaults and all valid bits.
// The receiver cannot stall, so the pipeline advances every cycle.
module two_link_arm_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [17:0] i_x_pos,
    input  logic signed [17:0] i_y_pos,
    output logic               o_done,
    output logic [14:0]        o_shoulder_angle,
    output logic [14:0]        o_elbow_angle,
    output logic               o_out_of_reach,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tlik_pkg::*;

    logic [15:0] r_a1;
    logic [15:0] r_a2;
    logic        w_wr;

    t_side       n_s1;
    t_side       r_s1;
    t_side       r_s2;
    logic [35:0] r_xx;
    logic [35:0] r_yy;
    logic [31:0] r_aa1;
    logic [31:0] r_aa2;
    logic [31:0] r_a12;

    logic signed [37:0] w_num;
    logic signed [37:0] w_den_ext;
    logic signed [37:0] w_mag;
    t_side              n_s3;
    t_side              r_s3;
    logic [33:0]        r_rem0;
    logic [32:0]        r_den0;

    t_side       w_dside [DIV_STEPS+1];
    logic [33:0] w_drem  [DIV_STEPS+1];
    logic [32:0] w_dden  [DIV_STEPS+1];
    logic [28:0] w_dquo  [DIV_STEPS+1];

    logic [28:0]        w_q;
    logic [57:0]        w_qsq;
    t_side              n_sq;
    t_side              r_sq;
    logic [57:0]        r_qq;
    t_side              r_sv;
    logic [57:0]        r_v;

    t_side       w_sside [SQRT_STEPS+1];
    logic [57:0] w_sv    [SQRT_STEPS+1];
    logic [31:0] w_srem  [SQRT_STEPS+1];
    logic [28:0] w_sroot [SQRT_STEPS+1];

    t_side              r_sm;
    logic [28:0]        r_ms;
    logic [44:0]        r_n2;
    logic signed [46:0] r_a2c;
    t_side              r_sd;
    logic [28:0]        r_ds;
    logic [44:0]        r_dn2;
    logic signed [46:0] r_d2;

    logic signed [18:0] w_xe;
    logic signed [18:0] w_ye;
    logic signed [18:0] w_n;
    logic signed [46:0] w_d2abs;
    logic [29:0]        w_cabs;

    logic [MAG_W-1:0] r_e_ax, r_e_ay, r_a_ax, r_a_ay, r_b_ax, r_b_ay;
    logic             r_e_zero, r_a_zero, r_a_half, r_a_neg;
    logic             r_b_zero, r_b_half, r_b_neg;
    logic [MAG_W-1:0] w_e_ax, w_e_ay, w_a_ax, w_a_ay, w_b_ax, w_b_ay;
    logic             r_p_valid, r_p_oor, r_p_cn;

    logic [2:0] r_dly [VEC_LAT];

    logic signed [ANG_W-1:0] w_ze;
    logic signed [ANG_W-1:0] w_za;
    logic signed [ANG_W-1:0] w_zb;
    logic signed [33:0]      w_p;
    logic signed [33:0]      r_f_q2;
    logic signed [33:0]      r_f_p1;
    logic                    r_f_valid;
    logic                    r_f_oor;

    logic        r_done;
    logic [14:0] r_sh;
    logic [14:0] r_el;
    logic        r_oor;

    // register port
    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_A2) ? {16'b0, r_a2} : {16'b0, r_a1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 16'd4410;
            r_a2 <= 16'd2496;
        end else if (w_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_A1:  r_a1 <= pwdata[15:0];
                REG_A2:  r_a2 <= pwdata[15:0];
                default: r_a1 <= r_a1;
            endcase
        end
    end

    // capture request
    always_comb begin
        n_s1       = '0;
        n_s1.valid = start && !busy;
        n_s1.x     = i_x_pos;
        n_s1.y     = i_y_pos;
        n_s1.a1    = r_a1;
        n_s1.a2    = r_a2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // squares and link product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx  <= unsigned'(36'(r_s1.x * r_s1.x));
        r_yy  <= unsigned'(36'(r_s1.y * r_s1.y));
        r_aa1 <= r_s1.a1 * r_s1.a1;
        r_aa2 <= r_s1.a2 * r_s1.a2;
        r_a12 <= r_s1.a1 * r_s1.a2;
    end

    // cosine numerator, reach test
    assign w_num = signed'({2'b00, r_xx}) + signed'({2'b00, r_yy})
                 - signed'({6'b0, r_aa1}) - signed'({6'b0, r_aa2});
    assign w_den_ext = signed'({5'b0, r_a12, 1'b0});
    assign w_mag     = (w_num < 0) ? -w_num : w_num;

    always_comb begin
        n_s3     = r_s2;
        n_s3.neg = w_num < 0;
        n_s3.oor = (r_a12 == '0) || (w_num > w_den_ext) || (-w_num > w_den_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem0 <= w_mag[33:0];
        r_den0 <= {r_a12, 1'b0};
    end

    // divider chain
    assign w_dside[0] = r_s3;
    assign w_drem[0]  = r_rem0;
    assign w_dden[0]  = r_den0;
    assign w_dquo[0]  = '0;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        tlik_div_cell u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (w_dside[i]),
            .i_rem  (w_drem[i]),
            .i_den  (w_dden[i]),
            .i_quo  (w_dquo[i]),
            .o_side (w_dside[i+1]),
            .o_rem  (w_drem[i+1]),
            .o_den  (w_dden[i+1]),
            .o_quo  (w_dquo[i+1])
        );
    end

    // signed ratio and radicand
    assign w_q   = w_dquo[DIV_STEPS];
    assign w_qsq = {29'b0, w_q} * {29'b0, w_q};

    always_comb begin
        n_sq   = w_dside[DIV_STEPS];
        n_sq.c = w_dside[DIV_STEPS].neg ? -signed'({1'b0, w_q}) : signed'({1'b0, w_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
            r_sv <= '0;
        end else begin
            r_sq <= n_sq;
            r_sv <= r_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qq <= w_qsq;
        r_v  <= (58'd1 << 56) - r_qq;
    end

    // square root chain
    assign w_sside[0] = r_sv;
    assign w_sv[0]    = r_v;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        tlik_sqrt_cell u_sqrt (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_side (w_sside[i]),
            .i_v    (w_sv[i]),
            .i_rem  (w_srem[i]),
            .i_root (w_sroot[i]),
            .o_side (w_sside[i+1]),
            .o_v    (w_sv[i+1]),
            .o_rem  (w_srem[i+1]),
            .o_root (w_sroot[i+1])
        );
    end

    // second atan operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm <= '0;
            r_sd <= '0;
        end else begin
            r_sm <= w_sside[SQRT_STEPS];
            r_sd <= r_sm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ms  <= w_sroot[SQRT_STEPS];
        r_n2  <= w_sside[SQRT_STEPS].a2 * w_sroot[SQRT_STEPS];
        r_a2c <= signed'({1'b0, w_sside[SQRT_STEPS].a2}) * w_sside[SQRT_STEPS].c;
        r_ds  <= r_ms;
        r_dn2 <= r_n2;
        r_d2  <= signed'({3'b000, r_sm.a1, 28'b0}) + r_a2c;
    end

    // vector unit operands
    assign w_xe    = 19'(r_sd.x);
    assign w_ye    = 19'(r_sd.y);
    assign w_n     = (w_xe < 0) ? -w_ye : w_ye;
    assign w_d2abs = (r_d2 < 0) ? -r_d2 : r_d2;
    assign w_cabs  = r_sd.c[29] ? unsigned'(-r_sd.c) : unsigned'(r_sd.c);

    assign w_e_ax = r_sd.c[29] ? MAG_W'(r_ds) : MAG_W'(w_cabs);
    assign w_e_ay = r_sd.c[29] ? MAG_W'(w_cabs) : MAG_W'(r_ds);
    assign w_a_ax = MAG_W'(unsigned'((w_xe < 0) ? -w_xe : w_xe));
    assign w_a_ay = MAG_W'(unsigned'((w_n < 0) ? -w_n : w_n));
    assign w_b_ax = w_d2abs[MAG_W-1:0];
    assign w_b_ay = MAG_W'(r_dn2);

    always_ff @(posedge i_clk) begin
        r_e_ax   <= w_e_ax;
        r_e_ay   <= w_e_ay;
        r_e_zero <= (w_e_ax == '0) && (w_e_ay == '0);
        r_a_ax   <= w_a_ax;
        r_a_ay   <= w_a_ay;
        r_a_neg  <= w_n < 0;
        r_a_half <= r_sd.x == '0;
        r_a_zero <= (w_a_ax == '0) && (w_a_ay == '0);
        r_b_ax   <= w_b_ax;
        r_b_ay   <= w_b_ay;
        r_b_neg  <= r_d2 < 0;
        r_b_half <= r_d2 == '0;
        r_b_zero <= (w_b_ax == '0) && (w_b_ay == '0);
        r_p_oor  <= r_sd.oor;
        r_p_cn   <= r_sd.c[29];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_sd.valid;
        end
    end

    tlik_vec u_vec_elbow (
        .i_clk (i_clk),
        .i_ax  (r_e_ax),
        .i_ay  (r_e_ay),
        .i_neg (1'b0),
        .i_zero(r_e_zero),
        .i_half(1'b0),
        .o_z   (w_ze)
    );

    tlik_vec u_vec_target (
        .i_clk (i_clk),
        .i_ax  (r_a_ax),
        .i_ay  (r_a_ay),
        .i_neg (r_a_neg),
        .i_zero(r_a_zero),
        .i_half(r_a_half),
        .o_z   (w_za)
    );

    tlik_vec u_vec_offset (
        .i_clk (i_clk),
        .i_ax  (r_b_ax),
        .i_ay  (r_b_ay),
        .i_neg (r_b_neg),
        .i_zero(r_b_zero),
        .i_half(r_b_half),
        .o_z   (w_zb)
    );

    // delay valid, reach and ratio sign across the vector units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < VEC_LAT; j++) begin
                r_dly[j] <= '0;
            end
        end else begin
            r_dly[0] <= {r_p_valid, r_p_oor, r_p_cn};
            for (int j = 1; j < VEC_LAT; j++) begin
                r_dly[j] <= r_dly[j-1];
            end
        end
    end

    // combine angles
    assign w_p = 34'(w_za) - 34'(w_zb);

    always_ff @(posedge i_clk) begin
        r_f_q2 <= r_dly[VEC_LAT-1][0] ? (34'(w_ze) + 34'(HALF_PI_Q30)) : 34'(w_ze);
        r_f_p1 <= (w_p < 0) ? (w_p + PI_Q30) : w_p;
        r_f_oor <= r_dly[VEC_LAT-1][1];
        r_sh   <= r_f_oor ? '0 : to_code(r_f_p1);
        r_el   <= r_f_oor ? '0 : to_code(r_f_q2);
        r_oor  <= r_f_oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_f_valid <= r_dly[VEC_LAT-1][2];
            r_done    <= r_f_valid;
        end
    end

    assign o_done           = r_done;
    assign o_shoulder_angle = r_sh;
    assign o_elbow_angle    = r_el;
    assign o_out_of_reach   = r_oor;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##PIPE_LAT o_done)
        else $error("request produced no result at the expected cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, PIPE_LAT))
        else $error("result strobe without a matching request");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out_of_reach |-> o_shoulder_angle == '0 && o_elbow_angle == '0)
        else $error("angles not cleared for an unreachable target");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_shoulder_angle <= PI_CODE && o_elbow_angle <= PI_CODE)
        else $error("angle beyond pi");

endmodule

### sv/tlik_div_cell.sv
// One restoring division step: one quotient bit per cell.
module tlik_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlik_pkg::t_side i_side,
    input  logic [33:0]     i_rem,
    input  logic [32:0]     i_den,
    input  logic [28:0]     i_quo,
    output tlik_pkg::t_side o_side,
    output logic [33:0]     o_rem,
    output logic [32:0]     o_den,
    output logic [28:0]     o_quo
);
    import tlik_pkg::*;

    t_side       r_side;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [28:0] r_quo;
    logic        w_ge;
    logic [33:0] w_diff;
    logic [32:0] w_keep;

    assign w_ge   = i_rem >= {1'b0, i_den};
    assign w_diff = i_rem - {1'b0, i_den};
    assign w_keep = w_ge ? w_diff[32:0] : i_rem[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= {w_keep, 1'b0};
        r_den <= i_den;
        r_quo <= {i_quo[27:0], w_ge};
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;

endmodule

### sv/tlik_sqrt_cell.sv
// One integer square root step: two radicand bits in, one root bit out.
module tlik_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlik_pkg::t_side i_side,
    input  logic [57:0]     i_v,
    input  logic [31:0]     i_rem,
    input  logic [28:0]     i_root,
    output tlik_pkg::t_side o_side,
    output logic [57:0]     o_v,
    output logic [31:0]     o_rem,
    output logic [28:0]     o_root
);
    import tlik_pkg::*;

    t_side       r_side;
    logic [57:0] r_v;
    logic [31:0] r_rem;
    logic [28:0] r_root;
    logic [31:0] w_rt;
    logic [31:0] w_trial;
    logic        w_ge;

    assign w_rt    = {i_rem[29:0], i_v[57:56]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = w_rt >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= {i_v[55:0], 2'b00};
        r_rem  <= w_ge ? (w_rt - w_trial) : w_rt;
        r_root <= {i_root[27:0], w_ge};
    end

    assign o_side = r_side;
    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

### sv/tlik_rot_cell.sv
// One CORDIC vectoring micro-rotation.
module tlik_rot_cell (
    input  logic                                  i_clk,
    input  logic [4:0]                            i_idx,
    input  logic signed [tlik_pkg::ROT_W-1:0]     i_x,
    input  logic signed [tlik_pkg::ROT_W-1:0]     i_y,
    input  logic signed [tlik_pkg::ANG_W-1:0]     i_z,
    output logic signed [tlik_pkg::ROT_W-1:0]     o_x,
    output logic signed [tlik_pkg::ROT_W-1:0]     o_y,
    output logic signed [tlik_pkg::ANG_W-1:0]     o_z
);
    import tlik_pkg::*;

    logic signed [ROT_W-1:0] r_x;
    logic signed [ROT_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [ROT_W-1:0] w_dx;
    logic signed [ROT_W-1:0] w_dy;
    logic signed [ANG_W-1:0] w_ang;

    assign w_dx  = i_y >>> i_idx;
    assign w_dy  = i_x >>> i_idx;
    assign w_ang = signed'({3'b000, atan_entry(i_idx)});

    always_ff @(posedge i_clk) begin
        if (!i_y[ROT_W-1]) begin
            r_x <= i_x + w_dx;
            r_y <= i_y - w_dy;
            r_z <= i_z + w_ang;
        end else begin
            r_x <= i_x - w_dx;
            r_y <= i_y + w_dy;
            r_z <= i_z - w_ang;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

### sv/tlik_vec.sv
// Vector angle unit: normalize magnitudes, then a chain of rotation cells.
module tlik_vec (
    input  logic                                i_clk,
    input  logic [tlik_pkg::MAG_W-1:0]          i_ax,
    input  logic [tlik_pkg::MAG_W-1:0]          i_ay,
    input  logic                                i_neg,
    input  logic                                i_zero,
    input  logic                                i_half,
    output logic signed [tlik_pkg::ANG_W-1:0]   o_z
);
    import tlik_pkg::*;

    logic [MAG_W-1:0]        w_ax  [NORM_STEPS+1];
    logic [MAG_W-1:0]        w_ay  [NORM_STEPS+1];
    logic                    w_neg [NORM_STEPS+1];
    logic signed [ROT_W-1:0] w_x   [ROT_STAGES+1];
    logic signed [ROT_W-1:0] w_y   [ROT_STAGES+1];
    logic signed [ANG_W-1:0] w_z   [ROT_STAGES+1];
    logic [1:0]              r_flag [VEC_LAT];
    logic signed [ROT_W-1:0] w_x0;

    assign w_ax[0]  = i_ax;
    assign w_ay[0]  = i_ay;
    assign w_neg[0] = i_neg;

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 16 >> (k % NORM_HALF);
        localparam bit RIGHT = (k < NORM_HALF);
        localparam logic [MAG_W-1:0] LIM = RIGHT ? (MAG_W'(1) << (29 + SH))
                                                 : (MAG_W'(1) << (30 - SH));
        logic [MAG_W-1:0] w_mx;
        logic             w_hit;
        logic [MAG_W-1:0] r_ax;
        logic [MAG_W-1:0] r_ay;
        logic             r_neg;

        assign w_mx  = (w_ax[k] > w_ay[k]) ? w_ax[k] : w_ay[k];
        assign w_hit = RIGHT ? (w_mx >= LIM) : (w_mx < LIM);

        always_ff @(posedge i_clk) begin
            if (w_hit && RIGHT) begin
                r_ax <= w_ax[k] >> SH;
                r_ay <= w_ay[k] >> SH;
            end else if (w_hit) begin
                r_ax <= w_ax[k] << SH;
                r_ay <= w_ay[k] << SH;
            end else begin
                r_ax <= w_ax[k];
                r_ay <= w_ay[k];
            end
            r_neg <= w_neg[k];
        end

        assign w_ax[k+1]  = r_ax;
        assign w_ay[k+1]  = r_ay;
        assign w_neg[k+1] = r_neg;
    end

    assign w_x0   = signed'({4'b0000, w_ax[NORM_STEPS][29:0]});
    assign w_x[0] = w_x0;
    assign w_y[0] = w_neg[NORM_STEPS] ? -signed'({4'b0000, w_ay[NORM_STEPS][29:0]})
                                      : signed'({4'b0000, w_ay[NORM_STEPS][29:0]});
    assign w_z[0] = '0;

    for (genvar i = 0; i < ROT_STAGES; i++) begin : g_rot
        tlik_rot_cell u_cell (
            .i_clk (i_clk),
            .i_idx (5'(i)),
            .i_x   (w_x[i]),
            .i_y   (w_y[i]),
            .i_z   (w_z[i]),
            .o_x   (w_x[i+1]),
            .o_y   (w_y[i+1]),
            .o_z   (w_z[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_flag[0] <= {i_half, i_zero};
        for (int j = 1; j < VEC_LAT; j++) begin
            r_flag[j] <= r_flag[j-1];
        end
    end

    assign o_z = r_flag[VEC_LAT-1][1] ? HALF_PI_Q30 :
                 r_flag[VEC_LAT-1][0] ? '0 : w_z[ROT_STAGES];

endmodule
